[sv/aawf_pkg.sv]
package aawf_pkg;

	// Operation codes; codes twelve to fifteen leave the state unchanged.
	typedef enum logic [3:0] {
		OP_LOAD = 4'd0,
		OP_NAND = 4'd1,
		OP_ADD  = 4'd2,
		OP_SUB  = 4'd3,
		OP_AND  = 4'd4,
		OP_OR   = 4'd5,
		OP_XOR  = 4'd6,
		OP_NOT  = 4'd7,
		OP_NEG  = 4'd8,
		OP_SAR1 = 4'd9,
		OP_LSH  = 4'd10,
		OP_MUL  = 4'd11
	} op_t;

	localparam int unsigned OP_BITS      = 4;
	localparam int unsigned OPERAND_BITS = 16;
	localparam int unsigned COUNT_BITS   = 6;
	localparam int unsigned IN_BITS      = 32;
	localparam int unsigned OUT_BITS     = 24;

	// Controller to datapath
	typedef struct packed {
		logic load;  // capture a new request
		logic step;  // advance the operation by one step
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;  // the current step finishes the operation
	} sts_t;

endpackage

[sv/aawf_ctrl.sv]
module aawf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output aawf_pkg::cmd_t  cmd,
	input  aawf_pkg::sts_t  sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_RUN;
			end
			ST_RUN: begin
				if (sts.last) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load  = in_ready && in_valid;
	assign cmd.step  = (state_q == ST_RUN);

endmodule

[sv/aawf_dp.sv]
module aawf_dp #(
	parameter int WORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  aawf_pkg::cmd_t                       cmd,
	output aawf_pkg::sts_t                       sts,
	input  logic [aawf_pkg::OP_BITS-1:0]         op_in,
	input  logic [aawf_pkg::OPERAND_BITS-1:0]    operand_in,
	input  logic [aawf_pkg::COUNT_BITS-1:0]      count_in,
	output logic [aawf_pkg::OPERAND_BITS-1:0]    acc_out,
	output logic                                 zf_out,
	output logic                                 cf_out,
	output logic                                 of_out,
	output logic                                 nf_out
);

	localparam int W   = WORD_BITS;
	localparam int EXT = (WORD_BITS > 16) ? WORD_BITS : 16;
	localparam int CB  = aawf_pkg::COUNT_BITS;

	logic [W-1:0]       acc_q;
	logic               zf_q, cf_q, of_q, nf_q;
	aawf_pkg::op_t      op_q;
	logic [W-1:0]       b_q, m_q, p_q;
	logic [CB-1:0]      cnt_q;
	logic               dir_q;  // 1: shift right

	logic [EXT-1:0]     operand_ext;
	logic [EXT-1:0]     acc_ext;
	logic [W-1:0]       b_in;
	logic [CB-1:0]      cnt_in;

	logic [W-1:0]       add_a, add_b;
	logic [W:0]         sum;
	logic               cout, cin;
	logic [W-1:0]       p_nx, acc_nx;
	logic               zf_nx, cf_nx, of_nx, nf_nx;
	logic               last;

	assign operand_ext = EXT'($signed(operand_in));
	assign b_in        = operand_ext[W-1:0];
	assign cnt_in      = count_in[CB-1] ? CB'(~count_in + 1'b1) : count_in;

	// Adder operand selection
	always_comb begin
		add_a = acc_q;
		add_b = b_q;
		case (op_q)
			aawf_pkg::OP_SUB: add_b = W'(~b_q + 1'b1);
			aawf_pkg::OP_NEG: begin
				add_a = ~acc_q;
				add_b = W'(1);
			end
			aawf_pkg::OP_LSH: add_b = acc_q;
			default: ;
		endcase
	end

	assign sum  = {1'b0, add_a} + {1'b0, add_b};
	assign cout = sum[W];
	assign cin  = sum[W-1] ^ add_a[W-1] ^ add_b[W-1];
	assign p_nx = b_q[0] ? W'(p_q + m_q) : p_q;

	always_comb begin
		acc_nx = acc_q;
		zf_nx  = zf_q;
		cf_nx  = cf_q;
		of_nx  = of_q;
		nf_nx  = nf_q;
		last   = 1'b1;
		case (op_q)
			aawf_pkg::OP_LOAD: acc_nx = b_q;
			aawf_pkg::OP_NAND: acc_nx = ~(acc_q & b_q);
			aawf_pkg::OP_AND:  acc_nx = acc_q & b_q;
			aawf_pkg::OP_OR:   acc_nx = acc_q | b_q;
			aawf_pkg::OP_XOR:  acc_nx = acc_q ^ b_q;
			aawf_pkg::OP_NOT:  acc_nx = ~acc_q;
			aawf_pkg::OP_ADD, aawf_pkg::OP_SUB, aawf_pkg::OP_NEG: begin
				acc_nx = sum[W-1:0];
				cf_nx  = cout;
				of_nx  = cin ^ cout;
			end
			aawf_pkg::OP_SAR1: acc_nx = {acc_q[W-1], acc_q[W-1:1]};
			aawf_pkg::OP_LSH: begin
				last = (cnt_q <= CB'(1));
				if (cnt_q != '0) begin
					if (!dir_q) begin
						acc_nx = sum[W-1:0];
						cf_nx  = cout;
						of_nx  = cin ^ cout;
					end else begin
						acc_nx = {1'b0, acc_q[W-1:1]};
						cf_nx  = acc_q[0];
					end
				end
			end
			aawf_pkg::OP_MUL: begin
				last = (b_q[W-1:1] == '0);
				if (last) acc_nx = p_nx;
			end
			default: ;
		endcase
		// ZF tracks every update; NF only where the operation writes it
		case (op_q)
			aawf_pkg::OP_SAR1: zf_nx = (acc_nx == '0);
			aawf_pkg::OP_LSH: begin
				if (cnt_q != '0) begin
					zf_nx = (acc_nx == '0);
					if (!dir_q) nf_nx = acc_nx[W-1];
				end
			end
			aawf_pkg::OP_MUL: begin
				if (last) begin
					zf_nx = (acc_nx == '0);
					nf_nx = acc_nx[W-1];
				end
			end
			aawf_pkg::OP_LOAD, aawf_pkg::OP_NAND, aawf_pkg::OP_ADD, aawf_pkg::OP_SUB,
			aawf_pkg::OP_AND, aawf_pkg::OP_OR, aawf_pkg::OP_XOR, aawf_pkg::OP_NOT,
			aawf_pkg::OP_NEG: begin
				zf_nx = (acc_nx == '0);
				nf_nx = acc_nx[W-1];
			end
			default: ;
		endcase
	end

	assign sts.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			zf_q  <= 1'b0;
			cf_q  <= 1'b0;
			of_q  <= 1'b0;
			nf_q  <= 1'b0;
		end else if (cmd.step) begin
			acc_q <= acc_nx;
			zf_q  <= zf_nx;
			cf_q  <= cf_nx;
			of_q  <= of_nx;
			nf_q  <= nf_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= aawf_pkg::op_t'(op_in);
			b_q   <= b_in;
			cnt_q <= cnt_in;
			dir_q <= count_in[CB-1];
			m_q   <= acc_q;
			p_q   <= '0;
		end else if (cmd.step) begin
			if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			m_q <= {m_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
			p_q <= p_nx;
		end
	end

	assign acc_ext = EXT'($signed(acc_q));
	assign acc_out = acc_ext[aawf_pkg::OPERAND_BITS-1:0];
	assign zf_out  = zf_q;
	assign cf_out  = cf_q;
	assign of_out  = of_q;
	assign nf_out  = nf_q;

endmodule

[sv/accumulator_alu_with_flags.sv]
// Channel   Direction  Request contents
// s_axis    in         one operation: opcode, operand, shift distance
// m_axis    out        accumulator after the operation and the four flags
//
// A request is taken in IDLE, worked in RUN and shown in OUT. In RUN, lshift moves
// the accumulator one bit position per step until the shift distance is used up;
// mul takes one multiplier bit per step and leaves RUN after the highest set bit,
// so it handles at most WORD_BITS multiplier bits.
// Reset clears the accumulator and all flags. A result held in OUT waits for
// m_tready; no new request is taken until it is delivered.
module accumulator_alu_with_flags #(
	parameter int WORD_BITS = 16  // accumulator width, 4 to 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: [3:0] op, [19:4] operand, [25:20] shift_count, [31:26] zero
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [aawf_pkg::IN_BITS-1:0]  s_tdata,
	// m_tdata: [15:0] acc_value, [16] zero_flag, [17] carry_flag,
	//          [18] overflow_flag, [19] negative_flag, [23:20] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [aawf_pkg::OUT_BITS-1:0] m_tdata
);

	aawf_pkg::cmd_t cmd;
	aawf_pkg::sts_t sts;

	logic [aawf_pkg::OP_BITS-1:0]      op;
	logic [aawf_pkg::OPERAND_BITS-1:0] operand;
	logic [aawf_pkg::COUNT_BITS-1:0]   shift_count;
	logic [aawf_pkg::OPERAND_BITS-1:0] acc_value;
	logic                              zero_flag, carry_flag, overflow_flag, negative_flag;

	// Unpack the request fields
	assign op          = s_tdata[3:0];
	assign operand     = s_tdata[19:4];
	assign shift_count = s_tdata[25:20];

	// Sequence accept, run and deliver
	aawf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Accumulator, flags, shift counter and multiply registers
	aawf_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op_in      (op),
		.operand_in (operand),
		.count_in   (shift_count),
		.acc_out    (acc_value),
		.zf_out     (zero_flag),
		.cf_out     (carry_flag),
		.of_out     (overflow_flag),
		.nf_out     (negative_flag)
	);

	// Hold the result straight from the state registers; they do not move in OUT
	assign m_tdata = {4'b0000, negative_flag, overflow_flag, carry_flag, zero_flag,
		acc_value};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int ACC_BITS      = 16;
	localparam int RANDOM_ITEMS  = 1625;
	localparam int PAUSE_AT      = 800;     // sender waits here until every result is back
	localparam int STEADY_FROM   = 1000;    // sender runs without gaps from here ...
	localparam int STEADY_TO     = 1200;    // ... up to here
	localparam int HOLD_AFTER    = 500;     // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 4 * (ACC_BITS + 2);
	localparam int DIRECTED_ROWS = 24;

	// Op codes with no operation behind them
	localparam logic [3:0] OP_UNDEF_LO = 4'd12;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	// Same bit order as m_tdata[19:0]
	typedef struct packed {
		logic        n;
		logic        o;
		logic        c;
		logic        z;
		logic [15:0] acc;
	} alu_result_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [15:0]       operand;
		logic signed [5:0] count;
		logic              known;  // want below is typed in, not predicted
		alu_result_t       want;
	} stim_row_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [aawf_pkg::IN_BITS-1:0]  s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [aawf_pkg::OUT_BITS-1:0] m_tdata;

	alu_result_t alu_state = '0;    // predicted accumulator and flags
	alu_result_t results_due[$];    // predicted results not yet delivered
	int          mismatches = 0;
	int          results_seen = 0;

	// Directed walk from reset: extremes, every op, the named corner cases
	stim_row_t directed [DIRECTED_ROWS] = '{
		'{OP_UNDEF_HI,       16'h0000, 6'sd0,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000}},
		'{aawf_pkg::OP_LOAD, 16'h7FFF, 6'sd0,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 16'h7FFF}},
		'{aawf_pkg::OP_ADD,  16'h0001, 6'sd0,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 16'h8000}},
		'{aawf_pkg::OP_SUB,  16'h0001, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_SUB,  16'h0000, 6'sd0,   1'b0, '0},  // zero operand keeps carry clear
		'{aawf_pkg::OP_LOAD, 16'h8000, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_NEG,  16'h0000, 6'sd0,   1'b0, '0},  // most negative value overflows
		'{aawf_pkg::OP_NAND, 16'hFFFF, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_AND,  16'h0F0F, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_OR,   16'hF0F0, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_XOR,  16'hFFFF, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_NOT,  16'h0000, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_SAR1, 16'h0000, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_LOAD, 16'h0001, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_SAR1, 16'h0000, 6'sd0,   1'b0, '0},  // shifts down to zero
		'{aawf_pkg::OP_LOAD, 16'h8001, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_LSH,  16'h0000, 6'sd1,   1'b0, '0},  // carry out of the top bit
		'{aawf_pkg::OP_LSH,  16'h0000, -6'sd1,  1'b0, '0},
		'{aawf_pkg::OP_LSH,  16'h0000, -6'sd16, 1'b0, '0},  // right past the whole word
		'{aawf_pkg::OP_LSH,  16'h0000, 6'sd16,  1'b0, '0},
		'{aawf_pkg::OP_LSH,  16'h0000, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_LOAD, 16'hFFFF, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_MUL,  16'hFFFF, 6'sd0,   1'b0, '0},
		'{aawf_pkg::OP_MUL,  16'h0000, 6'sd0,   1'b0, '0}   // zero multiplier still runs a step
	};

	accumulator_alu_with_flags #(
		.WORD_BITS(ACC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void update_zn();
		alu_state.z = (alu_state.acc == 16'h0000);
		alu_state.n = alu_state.acc[15];
	endfunction

	// One addition with all four flags; overflow is carry into xor carry out of the MSB
	function automatic void add_into(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] sum;
		logic [15:0] low_sum;
		sum = {1'b0, a} + {1'b0, b};
		low_sum = {1'b0, a[14:0]} + {1'b0, b[14:0]};
		alu_state.acc = sum[15:0];
		alu_state.c = sum[16];
		alu_state.o = low_sum[15] ^ sum[16];
		update_zn();
	endfunction

	// Advance the predicted state by one request and return the result it shows
	function automatic alu_result_t apply_op(input logic [3:0] op, input logic [15:0] b,
			input logic signed [5:0] count);
		int          steps;
		logic [15:0] neg_b;
		logic [31:0] product;
		neg_b = ~b + 16'd1;
		case (op)
			aawf_pkg::OP_LOAD: begin
				alu_state.acc = b;
				update_zn();
			end
			aawf_pkg::OP_NAND: begin
				alu_state.acc = ~(alu_state.acc & b);
				update_zn();
			end
			aawf_pkg::OP_ADD: add_into(alu_state.acc, b);
			aawf_pkg::OP_SUB: add_into(alu_state.acc, neg_b);
			aawf_pkg::OP_AND: begin
				alu_state.acc = alu_state.acc & b;
				update_zn();
			end
			aawf_pkg::OP_OR: begin
				alu_state.acc = alu_state.acc | b;
				update_zn();
			end
			aawf_pkg::OP_XOR: begin
				alu_state.acc = alu_state.acc ^ b;
				update_zn();
			end
			aawf_pkg::OP_NOT: begin
				alu_state.acc = ~alu_state.acc;
				update_zn();
			end
			aawf_pkg::OP_NEG: add_into(~alu_state.acc, 16'd1);
			aawf_pkg::OP_SAR1: begin
				alu_state.acc = {alu_state.acc[15], alu_state.acc[15:1]};
				alu_state.z = (alu_state.acc == 16'h0000);
			end
			aawf_pkg::OP_LSH: begin
				// left steps double through the adder, right steps fill with zero
				for (steps = int'(count); steps > 0; steps--)
					add_into(alu_state.acc, alu_state.acc);
				for (steps = int'(count); steps < 0; steps++) begin
					alu_state.c = alu_state.acc[0];
					alu_state.acc = alu_state.acc >> 1;
					alu_state.z = (alu_state.acc == 16'h0000);
				end
			end
			aawf_pkg::OP_MUL: begin
				// carry and overflow are kept
				product = 32'(alu_state.acc) * 32'(b);
				alu_state.acc = product[15:0];
				update_zn();
			end
			default: ;
		endcase
		return alu_state;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one request, hold it until taken, then record what it must return
	task automatic send_request(input logic [3:0] op, input logic [15:0] operand,
			input logic signed [5:0] count, input logic known, input alu_result_t want);
		alu_result_t predicted;
		s_tdata <= {6'b0, count, operand, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_op(op, operand, count);
		results_due.push_back(known ? want : predicted);
	endtask

	// Check every delivered result against the oldest prediction
	always @(posedge clk) begin : watch_results
		alu_result_t got;
		alu_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[19:0];
			results_seen++;
			if (results_due.size() == 0) begin
				$display("%0t ns: result %h with no request outstanding", $time, got);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("acc_value", want.acc, got.acc);
				check_field("zero_flag", 16'(want.z), 16'(got.z));
				check_field("carry_flag", 16'(want.c), 16'(got.c));
				check_field("overflow_flag", 16'(want.o), 16'(got.o));
				check_field("negative_flag", 16'(want.n), 16'(got.n));
			end
		end
	end

	// Receiver: switch between stall patterns, with one long hold-off
	initial begin : drive_ready
		rx_mode_t rx_mode;
		int       rx_left;
		int       hold_left;
		int       phase;
		bit       hold_done;
		rx_mode = RX_ALWAYS;
		rx_left = 0;
		hold_left = 0;
		phase = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(RX_ALWAYS, RX_MOSTLY));
					rx_left = int'($urandom_range(50, 400));
				end
				rx_left--;
				phase++;
				case (rx_mode)
					RX_ALWAYS:      m_tready <= 1'b1;
					RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
					RX_ONE_IN_FOUR: m_tready <= (phase % 4 == 0);
					default:        m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Sender: reset, directed table, then random requests in bursts
	initial begin : drive_requests
		logic [3:0]        op;
		logic [15:0]       operand;
		logic signed [5:0] count;
		int                distance;
		int                burst_left;
		int                gap;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].op, directed[i].operand, directed[i].count,
				directed[i].known, directed[i].want);

		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (results_due.size() != 0);
			end
			if (burst_left == 0) begin
				burst_left = int'($urandom_range(1, 24));
				gap = (i >= STEADY_FROM && i < STEADY_TO) ? 0 : int'($urandom_range(0, 12));
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;

			// mostly real operations, a few codes that do nothing
			if ($urandom_range(0, 9) == 0)
				op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
			else
				op = 4'($urandom_range(aawf_pkg::OP_LOAD, aawf_pkg::OP_MUL));
			// lean on the extremes of the operand
			case ($urandom_range(0, 7))
				0:       operand = 16'h0000;
				1:       operand = 16'hFFFF;
				2:       operand = 16'h8000;
				3:       operand = 16'h7FFF;
				4:       operand = 16'h0001;
				default: operand = 16'($urandom);
			endcase
			distance = int'($urandom_range(0, 32)) - 16;
			count = distance[5:0];
			send_request(op, operand, count, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then give a stray result time to show up
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
